// File: rtl/core/dif_pkg.sv
`default_nettype none

package dif_pkg;

	// fixed field widths
	localparam int ID_W       = 8;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CNT_OUT_W  = 9;
	localparam int CFG_W      = 9;

	// number of distinct identifiers an 8-bit id can name
	localparam int ID_SPACE     = 1 << ID_W;
	localparam int MAX_VARS_DEF = 256;

	localparam logic [CFG_W-1:0] VAR_COUNT_RST = 9'd256;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUP       = 2'd1;
	localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

	// ring control for one cycle, at most one flag set
	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} ring_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/dif_ring.sv
`default_nettype none

module dif_ring #(
	parameter int DEPTH = dif_pkg::MAX_VARS_DEF,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dif_pkg::ring_ctl_t      ctl,
	input  wire logic [dif_pkg::ID_W-1:0] wr_id,
	output logic      [dif_pkg::ID_W-1:0] head_id
);
	import dif_pkg::*;

	logic [ID_W-1:0]  slot_mem [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] rd_addr;
	logic [ID_W-1:0]  rd_q;
	logic             byp_q;
	logic [ID_W-1:0]  byp_id_q;

	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	// prefetch the slot that will be at the head after this cycle
	assign rd_addr = ctl.clr ? '0 : (ctl.pop ? head_inc : head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (ctl.push) begin
					tail_q <= tail_inc;
				end
				if (ctl.pop) begin
					head_q <= head_inc;
				end
			end
			// write into the slot being prefetched: old data would be read
			byp_q <= ctl.push && (tail_q == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slot_mem[tail_q] <= wr_id;
		end
		rd_q     <= slot_mem[rd_addr];
		byp_id_q <= wr_id;
	end

	assign head_id = byp_q ? byp_id_q : rd_q;

endmodule

`default_nettype wire

// File: rtl/core/dedup_id_fifo.sv
// dedup_id_fifo: work queue of variable identifiers that holds each id at most once
//
// command channel: an item (action, var_id) is taken at a rising edge with start
// high and busy low. busy is never raised, so one item can be taken every cycle.
// actions: push enqueues var_id unless it is queued already or out of range,
// pop dequeues the oldest id, clear empties the queue and the membership bitmap.
// result channel: done is high for exactly one cycle per item, with status,
// popped_id, queued_count and is_empty valid in that cycle. the receiver cannot
// stall, so results are never held back. results come in item order.
// a taken item is held in the stage 1 input register, and its result in the result
// register. throughput: one item per cycle, set by the single pass through the
// bitmap lookup and the ring update between the stage 1 input register and the
// result register; the head slot is prefetched from the ring memory so a pop also
// fits in that single pass.
// configuration: cfg_we writes var_count; write it only while no item is in flight.
// reset (arst_n low, asynchronous): queue empty, bitmap clear, var_count = 256,
// no result pending. the ring memory itself is not cleared, its contents are only used
// after a push has written the slot.
`default_nettype none

module dedup_id_fifo #(
	parameter int MAX_VARS = dif_pkg::MAX_VARS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command channel
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [dif_pkg::ACT_W-1:0]   action,
	input  wire logic [dif_pkg::ID_W-1:0]    var_id,
	// result channel
	output logic                             done,
	output logic      [dif_pkg::STAT_W-1:0]  status,
	output logic      [dif_pkg::ID_W-1:0]    popped_id,
	output logic      [dif_pkg::CNT_OUT_W-1:0] queued_count,
	output logic                             is_empty,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic [dif_pkg::CFG_W-1:0]   cfg_wdata
);
	import dif_pkg::*;

	// queued ids are distinct and below both MAX_VARS and the id space,
	// so ring and bitmap only need that many entries
	localparam int MEMB_N = (MAX_VARS < ID_SPACE) ? MAX_VARS : ID_SPACE;
	localparam int MEMB_W = $clog2(MEMB_N);
	localparam int CNT_W  = $clog2(MEMB_N + 1);

	// stage 1 input register
	logic              valid_s1;
	logic [ACT_W-1:0]  action_s1;
	logic [ID_W-1:0]   var_id_s1;

	// queue state
	logic [CFG_W-1:0]  var_count_q;
	logic [CNT_W-1:0]  count_q;
	logic [MEMB_N-1:0] member_q;

	// result register
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   popped_q;
	logic [CNT_W-1:0]  cnt_out_q;

	// single pass logic
	ring_ctl_t         ctl;
	logic [STAT_W-1:0] st_nxt;
	logic [ID_W-1:0]   popped_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic [ID_W-1:0]   head_id;
	logic [MEMB_W-1:0] id_idx;
	logic [MEMB_W-1:0] pop_idx;
	logic              id_ok;
	logic              is_dup;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= action;
		var_id_s1 <= var_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= VAR_COUNT_RST;
		end else if (cfg_we) begin
			var_count_q <= cfg_wdata;
		end
	end

	// range check against the configured count and the built-in limit
	assign id_ok   = ({1'b0, var_id_s1} < var_count_q) && (int'(var_id_s1) < MAX_VARS);
	assign id_idx  = MEMB_W'(var_id_s1);
	assign is_dup  = member_q[id_idx];
	assign pop_idx = MEMB_W'(head_id);

	always_comb begin
		ctl        = '0;
		st_nxt     = ST_DONE;
		popped_nxt = '0;
		if (valid_s1) begin
			case (action_s1)
				ACT_PUSH: begin
					if (!id_ok) begin
						st_nxt = ST_RANGE;
					end else if (is_dup) begin
						st_nxt = ST_DUP;
					end else if (count_q != CNT_W'(MEMB_N)) begin
						ctl.push = 1'b1;
					end
				end
				ACT_POP: begin
					if (count_q == '0) begin
						st_nxt = ST_POP_EMPTY;
					end else begin
						ctl.pop    = 1'b1;
						popped_nxt = head_id;
					end
				end
				ACT_CLEAR: begin
					ctl.clr = 1'b1;
				end
				default: begin
					// unused code: no state change, status done
				end
			endcase
		end
	end

	always_comb begin
		if (ctl.clr) begin
			count_nxt = '0;
		end else if (ctl.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			member_q <= '0;
			done_q   <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= valid_s1;
			if (ctl.clr) begin
				member_q <= '0;
			end else begin
				if (ctl.push) begin
					member_q[id_idx] <= 1'b1;
				end
				if (ctl.pop) begin
					member_q[pop_idx] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= st_nxt;
		popped_q  <= popped_nxt;
		cnt_out_q <= count_nxt;
	end

	// ring storage with the head slot prefetched
	dif_ring #(
		.DEPTH (MEMB_N),
		.PTR_W (MEMB_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_id   (var_id_s1),
		.head_id (head_id)
	);

	assign done         = done_q;
	assign status       = status_q;
	assign popped_id    = popped_q;
	assign queued_count = CNT_OUT_W'(cnt_out_q);
	assign is_empty     = (cnt_out_q == '0);

endmodule

`default_nettype wire

// File: rtl/core/dif_chk.sv
`default_nettype none

module dif_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [dif_pkg::ACT_W-1:0]     action,
	input wire logic                          done,
	input wire logic [dif_pkg::STAT_W-1:0]    status,
	input wire logic [dif_pkg::ID_W-1:0]      popped_id,
	input wire logic [dif_pkg::CNT_OUT_W-1:0] queued_count,
	input wire logic                          is_empty
);
	import dif_pkg::*;

	// every taken item gives its result, through the stage 1 input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("no result for a taken item");

	// no result without a taken item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a taken item");

	// empty flag tracks the count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (queued_count == '0)))
		else $error("is_empty disagrees with queued_count");

	// a pop on empty leaves the queue empty and returns no id
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_POP_EMPTY) |-> is_empty && (popped_id == '0))
		else $error("bad pop on empty result");

	// the count moves by at most one between back to back results, except a clear
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && !$past(action == ACT_CLEAR, 2) |->
			(queued_count == $past(queued_count)) ||
			(queued_count == $past(queued_count) + 9'd1) ||
			(queued_count + 9'd1 == $past(queued_count)))
		else $error("queued_count jumped");

endmodule

bind dedup_id_fifo dif_chk u_dif_chk (.*);

`default_nettype wire

// File: tb/dedup_id_fifo_tb.sv
`default_nettype none

module dedup_id_fifo_tb;
	import dif_pkg::*;

	// the unused fourth action code, ignored by the block
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	localparam int ITEM_TARGET = 1750;
	localparam int CYCLE_LIMIT = 200000;
	// a result follows its item through the stage 1 input and result registers; this drain settles everything
	localparam int DRAIN_CYCLES = 4;

	// one result as the block reports it
	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [ID_W-1:0]      popped;
		logic [CNT_OUT_W-1:0] count;
		logic                 empty;
	} fifo_result_t;

	// mirror of the work queue plus the results it owes
	class workq_checker;
		bit                 in_queue [MAX_VARS_DEF];
		logic [ID_W-1:0]    ring [MAX_VARS_DEF];
		bit   [ID_W-1:0]    rd_ptr;
		bit   [ID_W-1:0]    wr_ptr;
		int                 depth;
		int                 id_limit;
		fifo_result_t       owed_results [$];
		int                 errors;
		int                 n_items;
		int                 n_queued;
		int                 n_dup;
		int                 n_range;
		int                 n_popped;
		int                 n_pop_empty;
		int                 n_clear;
		int                 n_limits;
		int                 max_depth;
		int                 n_wraps;

		function new();
			id_limit = VAR_COUNT_RST;
		endfunction

		function int outstanding();
			return owed_results.size();
		endfunction

		// work out the effect of an accepted item and queue its result
		function void take_item(logic [ACT_W-1:0] act, logic [ID_W-1:0] id);
			fifo_result_t r;
			r = '0;
			r.status = ST_DONE;
			n_items++;
			case (act)
				ACT_PUSH: begin
					if (int'(id) >= id_limit) begin
						r.status = ST_RANGE;
						n_range++;
					end else if (in_queue[id]) begin
						r.status = ST_DUP;
						n_dup++;
					end else if (depth < MAX_VARS_DEF) begin
						ring[wr_ptr] = id;
						wr_ptr++;
						if (wr_ptr == 0)
							n_wraps++;
						in_queue[id] = 1'b1;
						depth++;
						n_queued++;
					end
				end
				ACT_POP: begin
					if (depth == 0) begin
						r.status = ST_POP_EMPTY;
						n_pop_empty++;
					end else begin
						r.popped = ring[rd_ptr];
						rd_ptr++;
						in_queue[r.popped] = 1'b0;
						depth--;
						n_popped++;
					end
				end
				ACT_CLEAR: begin
					foreach (in_queue[i])
						in_queue[i] = 1'b0;
					rd_ptr = '0;
					wr_ptr = '0;
					depth = 0;
					n_clear++;
				end
				default: ;
			endcase
			if (depth > max_depth)
				max_depth = depth;
			r.count = depth[CNT_OUT_W-1:0];
			r.empty = (depth == 0);
			owed_results.insert(owed_results.size(), r);
		endfunction

		// compare a reported result against the oldest one owed
		function void check_result(fifo_result_t got);
			fifo_result_t want;
			if (owed_results.size() == 0) begin
				$error("result with nothing pending: status %0d popped_id %0d count %0d",
					got.status, got.popped, got.count);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.popped !== want.popped) begin
				$error("popped_id: expected %0d, actual %0d", want.popped, got.popped);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("queued_count: expected %0d, actual %0d", want.count, got.count);
				errors++;
			end
			if (got.empty !== want.empty) begin
				$error("is_empty: expected %0d, actual %0d", want.empty, got.empty);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [ACT_W-1:0]      action = ACT_PUSH;
	logic [ID_W-1:0]       var_id = '0;
	logic                  done;
	logic [STAT_W-1:0]     status;
	logic [ID_W-1:0]       popped_id;
	logic [CNT_OUT_W-1:0]  queued_count;
	logic                  is_empty;
	logic                  cfg_we = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = VAR_COUNT_RST;

	workq_checker chk;
	int  cycle_cnt = 0;
	// set per phase, or per item while filling: when high the sender never pauses between items
	bit  no_gaps = 1'b0;

	dedup_id_fifo u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.var_id       (var_id),
		.done         (done),
		.status       (status),
		.popped_id    (popped_id),
		.queued_count (queued_count),
		.is_empty     (is_empty),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #2 clk = ~clk;

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[dedup_id_fifo] ERROR");
			$finish;
		end
	end

	// sample both channels at the edge, before this edge's drives land
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				chk.check_result('{status, popped_id, queued_count, is_empty});
			if (start && !busy)
				chk.take_item(action, var_id);
		end
	end

	// present one item, with an optional random pause first, and hold it until taken
	task automatic issue(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id);
		int gap;
		bit taken;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		action <= act;
		var_id <= id;
		taken = 1'b0;
		// busy only moves at an edge, so its value at the falling edge holds for the next rise
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	// let the queue go quiet, then write var_count
	task automatic set_id_limit(input int lim);
		start <= 1'b0;
		do
			@(negedge clk);
		while (chk.outstanding() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		chk.id_limit = lim;
		chk.n_limits++;
	endtask

	// one random item shaped for the current limit
	task automatic random_item(input int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			// mostly legal ids, now and then anything at all
			if ($urandom_range(0, 9) == 0)
				issue(ACT_PUSH, ID_W'($urandom_range(0, 255)));
			else
				issue(ACT_PUSH, ID_W'($urandom_range(0, lim - 1)));
		end else if (r < 90) begin
			issue(ACT_POP, ID_W'($urandom_range(0, 255)));
		end else if (r < 93) begin
			issue(ACT_CLEAR, ID_W'($urandom_range(0, 255)));
		end else if (r < 96) begin
			issue(ACT_NONE, ID_W'($urandom_range(0, 255)));
		end else if (lim < MAX_VARS_DEF) begin
			issue(ACT_PUSH, ID_W'($urandom_range(lim, 255)));
		end else begin
			issue(ACT_PUSH, ID_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int perm [MAX_VARS_DEF];
		int lim;
		int phase;
		int j;
		int tmp;

		chk = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, both id extremes, duplicate, unused code, clear
		issue(ACT_POP, 8'h00);
		issue(ACT_PUSH, 8'h00);
		issue(ACT_PUSH, 8'hFF);
		issue(ACT_PUSH, 8'h00);
		issue(ACT_NONE, 8'hAA);
		issue(ACT_POP, 8'hFF);
		issue(ACT_POP, 8'h00);
		issue(ACT_PUSH, 8'h55);
		issue(ACT_CLEAR, 8'hFF);
		issue(ACT_POP, 8'h00);

		// lowering the limit keeps queued ids, only new pushes are refused
		issue(ACT_PUSH, 8'd200);
		issue(ACT_PUSH, 8'd100);
		issue(ACT_PUSH, 8'd3);
		set_id_limit(4);
		issue(ACT_POP, 8'h00);
		issue(ACT_PUSH, 8'd100);
		issue(ACT_PUSH, 8'd3);
		issue(ACT_POP, 8'h00);
		issue(ACT_POP, 8'h00);
		issue(ACT_POP, 8'h00);

		// smallest limit: only id zero is legal
		set_id_limit(1);
		issue(ACT_PUSH, 8'd1);
		issue(ACT_PUSH, 8'd0);
		issue(ACT_PUSH, 8'hFF);
		issue(ACT_PUSH, 8'd0);
		issue(ACT_CLEAR, 8'h00);

		// fill the ring to all 256 ids in shuffled order, then drain it past empty
		set_id_limit(MAX_VARS_DEF);
		no_gaps = 1'b1;
		foreach (perm[i])
			perm[i] = i;
		for (int i = MAX_VARS_DEF - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		foreach (perm[i]) begin
			no_gaps = (i < 128);
			issue(ACT_PUSH, ID_W'(perm[i]));
		end
		issue(ACT_PUSH, ID_W'(perm[$urandom_range(0, MAX_VARS_DEF - 1)]));
		repeat (MAX_VARS_DEF + 1)
			issue(ACT_POP, ID_W'($urandom_range(0, 255)));

		// random phases, each under its own limit; the first few take the extremes
		phase = 0;
		while (chk.n_items < ITEM_TARGET) begin
			case (phase)
				0: lim = 1;
				1: lim = MAX_VARS_DEF;
				2: lim = 2;
				3: lim = MAX_VARS_DEF - 1;
				default: lim = ($urandom_range(0, 2) == 0) ? $urandom_range(3, 16)
					: $urandom_range(1, MAX_VARS_DEF);
			endcase
			set_id_limit(lim);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(60, 160))
				random_item(lim);
			phase++;
		end

		// drain and settle
		start <= 1'b0;
		do
			@(negedge clk);
		while (chk.outstanding() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items: %0d queued, %0d duplicates, %0d out of range,",
			chk.n_items, chk.n_queued, chk.n_dup, chk.n_range);
		$display("%0d pops, %0d empty pops, %0d clears, %0d var_count writes,",
			chk.n_popped, chk.n_pop_empty, chk.n_clear, chk.n_limits);
		$display("deepest queue %0d ids, write pointer wrapped %0d times",
			chk.max_depth, chk.n_wraps);
		if (chk.errors == 0)
			$display("[dedup_id_fifo] OK");
		else
			$display("[dedup_id_fifo] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
